@@ sv/sps_pkg.sv @@
`default_nettype none

package sps_pkg;

  // register indexes (byte address = 8 * index)
  localparam logic [1:0] REG_STEP_MODE    = 2'd0;
  localparam logic [1:0] REG_COIL_COUNT   = 2'd1;
  localparam logic [1:0] REG_COIL_BIT_MAP = 2'd2;

  // step mode codes; the unused code behaves as half step
  localparam logic [1:0] MODE_WAVE = 2'd0;
  localparam logic [1:0] MODE_FULL = 2'd1;
  localparam logic [1:0] MODE_HALF = 2'd2;

  localparam int MASK_W     = 32;
  localparam int POS_W      = 4;
  localparam int MAP_W      = 40;
  localparam int COIL_IDX_W = 3;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  localparam logic [1:0]  RESET_STEP_MODE    = MODE_FULL;
  localparam logic [3:0]  RESET_COIL_COUNT   = 4'd4;
  localparam logic [39:0] RESET_COIL_BIT_MAP = 40'd100384;

  typedef struct packed {
    logic [3:0]        pad;
    logic [MASK_W-1:0] used_pins_mask;
    logic [POS_W-1:0]  phase_position;
    logic [MASK_W-1:0] coil_mask;
  } result_t;

  // one-hot output bit of coil k
  function automatic logic [MASK_W-1:0] coil_bit(input logic [MAP_W-1:0] map,
                                                 input logic [COIL_IDX_W-1:0] k);
    logic [4:0] b;
    b = map[5*k +: 5];
    return MASK_W'(1) << b;
  endfunction

endpackage

`default_nettype wire

@@ sv/stepper_phase_sequencer_core.sv @@
// Channel   Dir  Signals                       Contents (low bit up)
// s_        in   s_tvalid s_tready s_tdata     tdata[0] direction, [7:1] zero
//                s_tuser                       tuser[0] command (1 = realign)
// m_        out  m_tvalid m_tready m_tdata     [31:0] coil_mask, [35:32] phase_position,
//                                              [67:36] used_pins_mask, [71:68] zero
// apb       in   psel penable pwrite paddr     regs at 0x00 step_mode, 0x08 coil_count,
//                pwdata prdata pready          0x10 coil_bit_map
//
// One item per cycle while the skid entry is free; each result is registered. The phase
// update and coil mask lookup sit between the phase register and the output register.
// A two-entry output stage (main + skid) keeps input accepted while one result waits.
// Synchronous reset: phase 1, full step, four coils on bits 0..3, no pending results.
// A write to any of the three registers realigns the phase to the start of the mode in effect after it.
`default_nettype none

module stepper_phase_sequencer_core #(
  parameter int MAX_COILS = 8
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  output logic                             s_tready,
  input  wire  [sps_pkg::IN_DATA_W-1:0]    s_tdata,   // [0] direction
  input  wire                              s_tuser,   // [0] command
  output logic                             m_tvalid,
  input  wire                              m_tready,
  output logic [sps_pkg::OUT_DATA_W-1:0]   m_tdata,   // coil_mask, phase_position, used_pins_mask
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [sps_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire  [sps_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [sps_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import sps_pkg::*;

  localparam logic [3:0] MaxCoils = 4'(MAX_COILS);

  logic [1:0]       step_mode;
  logic [3:0]       coil_count;
  logic [MAP_W-1:0] coil_bit_map;
  logic [POS_W-1:0] phase_index;
  logic [POS_W-1:0] phase_next;

  result_t          out_reg, skid_reg, result_next;
  logic             out_valid, skid_valid;

  logic [1:0]       reg_idx;
  logic             cfg_we;
  logic [1:0]       mode_written;

  logic [3:0]       coils;
  logic [4:0]       size;
  logic [4:0]       inc;
  logic [4:0]       pos_ext;
  logic [4:0]       fwd, bwd;
  logic [COIL_IDX_W-1:0] coil_lo, coil_hi;
  logic [3:0]       coil_up;
  logic [MASK_W-1:0] used_mask;

  logic             in_xfer, out_xfer;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[4:3];
  assign cfg_we   = psel && penable && pwrite && pready;
  assign in_xfer  = s_tvalid && s_tready;
  assign out_xfer = m_tvalid && m_tready;
  assign s_tready = !skid_valid;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_reg;

  always_comb begin
    case (reg_idx)
      REG_STEP_MODE:    prdata = CFG_DATA_W'(step_mode);
      REG_COIL_COUNT:   prdata = CFG_DATA_W'(coil_count);
      REG_COIL_BIT_MAP: prdata = CFG_DATA_W'(coil_bit_map);
      default:          prdata = '0;
    endcase
  end

  // mode in effect after this write, for the realign
  assign mode_written = (reg_idx == REG_STEP_MODE) ? pwdata[1:0] : step_mode;

  always_comb begin
    if (coil_count == 4'd0) begin
      coils = 4'd1;
    end else if (coil_count > MaxCoils) begin
      coils = MaxCoils;
    end else begin
      coils = coil_count;
    end
  end

  assign size    = {coils, 1'b0};
  assign inc     = step_mode[1] ? 5'd1 : 5'd2;
  assign pos_ext = {1'b0, phase_index};
  assign fwd     = pos_ext + inc;
  assign bwd     = pos_ext + size - inc;

  // phase_index always stays below the table size
  always_comb begin
    if (s_tuser) begin
      phase_next = (step_mode == MODE_FULL) ? 4'd1 : 4'd0;
    end else if (!s_tdata[0]) begin
      phase_next = (fwd >= size) ? 4'(fwd - size) : fwd[3:0];
    end else begin
      phase_next = (bwd >= size) ? 4'(bwd - size) : bwd[3:0];
    end
  end

  assign coil_lo = phase_next[3:1];
  assign coil_up = {1'b0, coil_lo} + 4'd1;
  assign coil_hi = (coil_up == coils) ? '0 : coil_up[2:0];

  always_comb begin
    used_mask = '0;
    for (int k = 0; k < MAX_COILS; k++) begin
      if (4'(k) < coils) begin
        used_mask = used_mask | coil_bit(coil_bit_map, COIL_IDX_W'(k));
      end
    end
  end

  always_comb begin
    result_next.pad            = '0;
    result_next.used_pins_mask = used_mask;
    result_next.phase_position = phase_next;
    result_next.coil_mask      = coil_bit(coil_bit_map, coil_lo);
    if (phase_next[0]) begin
      result_next.coil_mask = result_next.coil_mask | coil_bit(coil_bit_map, coil_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_mode    <= RESET_STEP_MODE;
      coil_count   <= RESET_COIL_COUNT;
      coil_bit_map <= RESET_COIL_BIT_MAP;
      phase_index  <= 4'd1;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_STEP_MODE:    step_mode    <= pwdata[1:0];
        REG_COIL_COUNT:   coil_count   <= pwdata[3:0];
        REG_COIL_BIT_MAP: coil_bit_map <= pwdata[MAP_W-1:0];
        default: ;
      endcase
      if (reg_idx inside {REG_STEP_MODE, REG_COIL_COUNT, REG_COIL_BIT_MAP}) begin
        phase_index <= (mode_written == MODE_FULL) ? 4'd1 : 4'd0;
      end
    end else if (in_xfer) begin
      phase_index <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_xfer) begin
      if (!out_valid || out_xfer) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_xfer) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (!out_valid || out_xfer) begin
        out_reg <= result_next;
      end else begin
        skid_reg <= result_next;
      end
    end else if (out_xfer && skid_valid) begin
      out_reg <= skid_reg;
    end
  end

endmodule

`default_nettype wire

@@ sv/sps_checker.sv @@
`default_nettype none

module sps_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            s_tvalid,
  input wire                            s_tready,
  input wire                            m_tvalid,
  input wire                            m_tready,
  input wire [sps_pkg::OUT_DATA_W-1:0]  m_tdata
);
  import sps_pkg::*;

  result_t res;
  assign res = m_tdata;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_mask_in_used: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (res.coil_mask & ~res.used_pins_mask) == '0)
    else $error("coil mask outside used pins");

  a_mask_bits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($countones(res.coil_mask) == 1 || $countones(res.coil_mask) == 2))
    else $error("coil mask must energize one or two bits");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> m_tvalid)
    else $error("accepted item produced no result");

endmodule

bind stepper_phase_sequencer_core sps_checker u_sps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

@@ tb/stepper_phase_sequencer_checker.sv @@
`timescale 1ns / 1ps

module stepper_phase_sequencer_checker (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            s_tvalid,
  input  wire                            s_tready,
  input  wire  [sps_pkg::IN_DATA_W-1:0]  s_tdata,   // [0] direction
  input  wire                            s_tuser,   // [0] command
  input  wire                            m_tvalid,
  input  wire                            m_tready,
  input  wire  [sps_pkg::OUT_DATA_W-1:0] m_tdata,   // coil_mask, phase_position, used_pins_mask
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [sps_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire  [sps_pkg::CFG_DATA_W-1:0] pwdata,
  input  wire                            pready,
  output int                             errors,
  output int                             pending
);
  import sps_pkg::*;

  localparam int MAX_COIL_PINS = 8;

  logic [1:0]       mode;
  logic [3:0]       coils_cfg;
  logic [MAP_W-1:0] bit_map;
  logic [POS_W-1:0] phase;
  result_t          coil_q[$];

  function automatic logic [MASK_W-1:0] pin_of(input int k);
    return MASK_W'(1) << bit_map[5*k +: 5];
  endfunction

  function automatic logic [POS_W-1:0] mode_start();
    return (mode == MODE_FULL) ? POS_W'(1) : POS_W'(0);
  endfunction

  function automatic void apply_write(input logic [CFG_ADDR_W-1:0] addr,
                                      input logic [CFG_DATA_W-1:0] data);
    case (addr[CFG_ADDR_W-1:3])
      REG_STEP_MODE:    mode = data[1:0];
      REG_COIL_COUNT:   coils_cfg = data[3:0];
      REG_COIL_BIT_MAP: bit_map = data[MAP_W-1:0];
      default:          return;
    endcase
    phase = mode_start();
  endfunction

  // advances or realigns the phase position for one command and returns the coil outputs
  function automatic result_t next_coil_output(input logic realign_cmd, input logic backward);
    result_t r;
    int c;
    int size;
    int pos;
    int inc;
    c = (coils_cfg == 0) ? 1 : (coils_cfg > MAX_COIL_PINS) ? MAX_COIL_PINS : int'(coils_cfg);
    size = 2 * c;
    if (realign_cmd) begin
      phase = mode_start();
    end else begin
      inc = (mode >= MODE_HALF) ? 1 : 2;
      pos = int'(phase) % size;
      pos = backward ? (pos + size - inc) % size : (pos + inc) % size;
      phase = POS_W'(pos);
    end
    pos = int'(phase) % size;
    r = '0;
    r.coil_mask = pin_of(pos / 2);
    if (pos % 2 != 0) r.coil_mask |= pin_of((pos / 2 + 1) % c);
    r.phase_position = POS_W'(pos);
    for (int k = 0; k < c; k++) r.used_pins_mask |= pin_of(k);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [MASK_W-1:0] want,
                                      input logic [MASK_W-1:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %h, got %h", name, want, got);
    end
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    if (rst) begin
      mode = RESET_STEP_MODE;
      coils_cfg = RESET_COIL_COUNT;
      bit_map = RESET_COIL_BIT_MAP;
      phase = POS_W'(1);
      coil_q.delete();
      errors = 0;
      pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) apply_write(paddr, pwdata);
      // pop before push: a result never belongs to the transfer of the same edge
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata);
        if (coil_q.size() == 0) begin
          errors++;
          $error("result with no expectation: %h", m_tdata);
        end else begin
          want = coil_q.pop_front();
          check_field("coil_mask", want.coil_mask, got.coil_mask);
          check_field("phase_position", MASK_W'(want.phase_position),
                      MASK_W'(got.phase_position));
          check_field("used_pins_mask", want.used_pins_mask, got.used_pins_mask);
          check_field("pad", MASK_W'(want.pad), MASK_W'(got.pad));
        end
      end
      if (s_tvalid && s_tready) coil_q = {coil_q, next_coil_output(s_tuser, s_tdata[0])};
      pending <= coil_q.size();
    end
  end

endmodule

@@ tb/tb_stepper_phase_sequencer_core.sv @@
`timescale 1ns / 1ps

module tb_stepper_phase_sequencer_core;
  import sps_pkg::*;

  localparam logic [1:0] MODE_UNDEF = 2'd3;
  localparam logic [1:0] REG_NONE   = 2'd3;
  localparam int ITEM_TARGET    = 1100;
  localparam int STALL_LIMIT    = 2000;
  localparam int HOLDOFF_CYCLES = 80;
  // coils 0..7 on bits 31, 0, 17, 5, 22, 9, 30, 1
  localparam logic [MAP_W-1:0] SPREAD_MAP =
    {5'd1, 5'd30, 5'd9, 5'd22, 5'd5, 5'd17, 5'd0, 5'd31};

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tuser = 1'b0;
  logic                  m_tready = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  wire                   s_tready;
  wire                   m_tvalid;
  wire [OUT_DATA_W-1:0]  m_tdata;
  wire [CFG_DATA_W-1:0]  prdata;
  wire                   pready;

  int errors;
  int pending;
  int sent = 0;
  int stall_cycles = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  stepper_phase_sequencer_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  stepper_phase_sequencer_checker coil_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // result side: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        m_tready <= recv_gaps ? ($urandom_range(0, 99) >= 21) : 1'b1;
      end
    end
  end

  task automatic send_item(input logic realign_cmd, input logic backward);
    while (send_gaps && $urandom_range(0, 99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= realign_cmd;
    s_tdata <= {{(IN_DATA_W-1){1'b0}}, backward};
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // back-to-back writes keep psel high; apb_release ends the burst
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apb_release();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_config();
    int n;
    logic [1:0] idx;
    logic [CFG_DATA_W-1:0] val;
    n = $urandom_range(1, 3);
    for (int i = 0; i < n; i++) begin
      idx = ($urandom_range(0, 9) == 0) ? REG_NONE : 2'($urandom_range(0, 2));
      val = {$urandom, $urandom};
      case (idx)
        REG_STEP_MODE: begin
          if ($urandom_range(0, 3) != 0) val[CFG_DATA_W-1:2] = '0;
        end
        REG_COIL_COUNT: begin
          val[3:0] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, 8));
          if ($urandom_range(0, 3) != 0) val[CFG_DATA_W-1:4] = '0;
        end
        REG_COIL_BIT_MAP: begin
          if ($urandom_range(0, 5) == 0) val[MAP_W-1:0] = '0;
          else if ($urandom_range(0, 4) == 0) val[MAP_W-1:0] = '1;
          if ($urandom_range(0, 3) != 0) val[CFG_DATA_W-1:MAP_W] = '0;
        end
        default: ;
      endcase
      write_reg(idx, val);
    end
    apb_release();
  endtask

  initial begin
    int n_items;
    int phase_no;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset setup: full step, four coils; walk past the wrap both ways
    repeat (4) send_item(1'b0, 1'b0);
    repeat (2) send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b1);
    drain();
    write_reg(REG_STEP_MODE, CFG_DATA_W'(MODE_WAVE));
    apb_release();
    send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b0);
    // single coil, half step: table of two entries
    drain();
    write_reg(REG_STEP_MODE, CFG_DATA_W'(MODE_HALF));
    write_reg(REG_COIL_COUNT, 64'd1);
    apb_release();
    send_item(1'b0, 1'b0);
    send_item(1'b0, 1'b0);
    send_item(1'b0, 1'b1);
    // all coils sharing the top bit
    drain();
    write_reg(REG_COIL_COUNT, 64'd8);
    write_reg(REG_COIL_BIT_MAP, {{(CFG_DATA_W-MAP_W){1'b0}}, {MAP_W{1'b1}}});
    apb_release();
    send_item(1'b0, 1'b0);
    send_item(1'b0, 1'b1);
    // undefined mode, oversized count with junk in the upper bits
    drain();
    write_reg(REG_STEP_MODE, CFG_DATA_W'(MODE_UNDEF));
    write_reg(REG_COIL_COUNT, '1);
    write_reg(REG_COIL_BIT_MAP, {{(CFG_DATA_W-MAP_W){1'b0}}, SPREAD_MAP});
    apb_release();
    send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    // zero count acts as one coil
    drain();
    write_reg(REG_COIL_COUNT, 64'd0);
    write_reg(REG_STEP_MODE, CFG_DATA_W'(MODE_FULL));
    apb_release();
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b0);
    // write to an address with no register behind it
    drain();
    write_reg(REG_NONE, '1);
    apb_release();
    send_item(1'b0, 1'b1);
    drain();
    write_reg(REG_COIL_COUNT, 64'd5);
    write_reg(REG_COIL_BIT_MAP, '0);
    apb_release();
    send_item(1'b0, 1'b0);
    send_item(1'b0, 1'b1);

    phase_no = 0;
    while (sent < ITEM_TARGET) begin
      drain();
      random_config();
      send_gaps = (phase_no != 2);
      recv_gaps = (phase_no != 2);
      if (phase_no == 4) hold_req = 1'b1;
      n_items = (phase_no == 2) ? 150 : $urandom_range(20, 90);
      for (int i = 0; i < n_items; i++) begin
        if (phase_no == 6 && i == n_items / 2) drain();
        send_item(1'($urandom_range(0, 7) == 0), 1'($urandom_range(0, 1)));
      end
      phase_no++;
    end
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
